### rtl/multiword_integer_alu_top_macros.svh
// Assertion macros used by the port-level checker.
// Depends on nothing; guarded against repeated inclusion.
`ifndef MULTIWORD_INTEGER_ALU_TOP_MACROS_SVH
`define MULTIWORD_INTEGER_ALU_TOP_MACROS_SVH
// implication checked every clock, disabled in reset
`define MIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/mia_pkg.sv
// Package for the multiword ALU: opcodes, actions and controller/datapath structs.
// Depends on nothing.
`timescale 1ns / 1ps
package mia_pkg;
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_EXEC   = 2'd2;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_DVM = 4'd5;
    localparam logic [3:0] OP_SHL = 4'd6;
    localparam logic [3:0] OP_SHR = 4'd7;
    localparam logic [3:0] OP_OR  = 4'd8;
    localparam logic [3:0] OP_CMP = 4'd9;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;      // write operand word from input
        logic       start;     // latch opcode/shift and begin evaluation
        logic       div_step;  // one restoring division step
        logic       mul_step;  // one word-product accumulate step
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic       b_zero;
        logic       flags_done; // compare / zero sweep finished
    } t_sts;
endpackage

### rtl/mia_dp.sv
// Datapath of the multiword ALU: operand stores, scratch, sequential units.
// Depends on mia_pkg.
`timescale 1ns / 1ps
module mia_dp #(
    parameter int NUM_WORDS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mia_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_action,
    input  logic [4:0]           i_word_index,
    input  logic [31:0]          i_word_value,
    input  logic [3:0]           i_opcode,
    input  logic [10:0]          i_shift_amount,
    input  logic [$clog2(NUM_WORDS)-1:0] i_widx,     // word selected for mul/output
    input  logic [$clog2(NUM_WORDS)-1:0] i_widx2,    // second index for mul
    input  logic                 i_mul_clr,
    input  logic                 i_sel_rem,
    output mia_pkg::t_sts        o_sts,
    output logic [31:0]          o_word,
    output logic [1:0]           o_compare,
    output logic                 o_a_is_zero
);
    localparam int WI  = $clog2(NUM_WORDS);
    localparam int N   = NUM_WORDS * WORD_BITS;
    localparam int BI  = $clog2(N);

    logic [WORD_BITS-1:0] r_a [NUM_WORDS];
    logic [WORD_BITS-1:0] r_b [NUM_WORDS];
    logic [N-1:0]         r_rem, r_quo, r_acc;
    logic [BI-1:0]        r_bit;
    logic [WI:0]          r_fi;
    logic [1:0]           r_cmp;
    logic                 r_az, r_bz, r_fdone;
    logic [3:0]           r_op;
    logic [10:0]          r_sh;

    logic [N-1:0] w_a, w_b;
    always_comb begin
        for (int k = 0; k < NUM_WORDS; k++) begin
            w_a[k*WORD_BITS +: WORD_BITS] = r_a[k];
            w_b[k*WORD_BITS +: WORD_BITS] = r_b[k];
        end
    end

    // division step: shift in next dividend bit, trial subtract
    logic [N:0]   w_sh_rem;
    logic [N:0]   w_diff;
    always_comb begin
        w_sh_rem = {r_rem, w_a[r_bit]};
        w_diff   = w_sh_rem - {1'b0, w_b};
    end

    // multiply step: acc += (a[i]*b[j]) << word offset (i+j), modulo 2^N
    logic [2*WORD_BITS-1:0] r_prod;
    logic [WI:0]            w_sum_idx;
    logic [N-1:0]           w_prod_sh;
    logic [WI:0]            r_pidx;
    logic                   r_pv;
    assign w_sum_idx = {1'b0, i_widx} + {1'b0, i_widx2};
    always_comb begin
        w_prod_sh = '0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            if (r_pidx == (WI+1)'(k)) begin
                w_prod_sh = N'({{N{1'b0}}, r_prod} << (k*WORD_BITS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_a[k] <= '0;
                r_b[k] <= '0;
            end
            r_fdone <= 1'b1;
            r_fi    <= '0;
            r_pv    <= 1'b0;
        end else begin
            if (i_cmd.load && {1'b0, i_word_index} < 6'(NUM_WORDS)) begin
                if (i_action == mia_pkg::ACT_LOAD_A) begin
                    r_a[i_word_index[WI-1:0]] <= i_word_value[WORD_BITS-1:0];
                end else begin
                    r_b[i_word_index[WI-1:0]] <= i_word_value[WORD_BITS-1:0];
                end
            end
            if (i_cmd.start) begin
                r_op    <= i_opcode;
                r_sh    <= i_shift_amount;
                r_bit   <= BI'(N-1);
                r_rem   <= '0;
                r_quo   <= '0;
                r_cmp   <= mia_pkg::CMP_EQ;
                r_az    <= 1'b1;
                r_bz    <= 1'b1;
                r_fi    <= (WI+1)'(NUM_WORDS);
                r_fdone <= 1'b0;
            end else if (!r_fdone) begin
                // sweep words from most significant down
                if (r_a[r_fi[WI-1:0]-WI'(1)] != '0) r_az <= 1'b0;
                if (r_b[r_fi[WI-1:0]-WI'(1)] != '0) r_bz <= 1'b0;
                if (r_cmp == mia_pkg::CMP_EQ) begin
                    if (r_a[r_fi[WI-1:0]-WI'(1)] > r_b[r_fi[WI-1:0]-WI'(1)])
                        r_cmp <= mia_pkg::CMP_GT;
                    else if (r_a[r_fi[WI-1:0]-WI'(1)] < r_b[r_fi[WI-1:0]-WI'(1)])
                        r_cmp <= mia_pkg::CMP_LT;
                end
                r_fi <= r_fi - (WI+1)'(1);
                if (r_fi == (WI+1)'(1)) r_fdone <= 1'b1;
            end
            if (i_cmd.div_step) begin
                if (w_sh_rem[N] || !w_diff[N]) begin
                    r_rem        <= w_diff[N-1:0];
                    r_quo[r_bit] <= 1'b1;
                end else begin
                    r_rem <= w_sh_rem[N-1:0];
                end
                r_bit <= r_bit - BI'(1);
            end
            if (i_mul_clr) begin
                r_acc <= '0;
                r_pv  <= 1'b0;
            end else begin
                r_pv <= i_cmd.mul_step && !w_sum_idx[WI] &&
                        (w_sum_idx < (WI+1)'(NUM_WORDS));
                r_prod <= (2*WORD_BITS)'(r_a[i_widx]) * (2*WORD_BITS)'(r_b[i_widx2]);
                r_pidx <= w_sum_idx;
                if (r_pv) r_acc <= r_acc + w_prod_sh;
            end
        end
    end

    assign o_sts.b_zero     = r_bz;
    assign o_sts.flags_done = r_fdone;
    assign o_compare        = r_cmp;
    assign o_a_is_zero      = r_az;

    // output word selection, one word per transfer
    logic [N-1:0] w_shl, w_shr;
    logic         w_big;
    assign w_big = r_sh >= 11'(N);
    assign w_shl = w_a << r_sh;
    assign w_shr = w_a >> r_sh;

    logic [WORD_BITS-1:0] w_sel;
    logic [WORD_BITS-1:0] w_aw, w_bw;
    always_comb begin
        w_aw = r_a[i_widx];
        w_bw = r_b[i_widx];
        case (r_op)
            mia_pkg::OP_ADD: w_sel = WORD_BITS'(N'(w_a + w_b) >> (i_widx*WORD_BITS));
            mia_pkg::OP_SUB: w_sel = WORD_BITS'(N'(w_a - w_b) >> (i_widx*WORD_BITS));
            mia_pkg::OP_MUL: w_sel = WORD_BITS'(r_acc >> (i_widx*WORD_BITS));
            mia_pkg::OP_DIV: w_sel = WORD_BITS'(r_quo >> (i_widx*WORD_BITS));
            mia_pkg::OP_MOD: w_sel = WORD_BITS'(r_rem >> (i_widx*WORD_BITS));
            mia_pkg::OP_DVM: w_sel = i_sel_rem ? WORD_BITS'(r_rem >> (i_widx*WORD_BITS))
                                               : WORD_BITS'(r_quo >> (i_widx*WORD_BITS));
            mia_pkg::OP_SHL: w_sel = w_big ? '0 : WORD_BITS'(w_shl >> (i_widx*WORD_BITS));
            mia_pkg::OP_SHR: w_sel = w_big ? '0 : WORD_BITS'(w_shr >> (i_widx*WORD_BITS));
            mia_pkg::OP_OR:  w_sel = w_aw | w_bw;
            default:         w_sel = '0;
        endcase
        if ((r_op == mia_pkg::OP_DIV || r_op == mia_pkg::OP_MOD ||
             r_op == mia_pkg::OP_DVM) && r_bz) w_sel = '0;
    end
    assign o_word = 32'(w_sel);
endmodule

### rtl/mia_ctrl.sv
// Controller state machine of the multiword ALU: sequencing and output handshake.
// Depends on mia_pkg.
`timescale 1ns / 1ps
module mia_ctrl #(
    parameter int NUM_WORDS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [3:0]           i_opcode,
    input  mia_pkg::t_sts        i_sts,
    output mia_pkg::t_cmd        o_cmd,
    output logic [$clog2(NUM_WORDS)-1:0] o_widx,
    output logic [$clog2(NUM_WORDS)-1:0] o_widx2,
    output logic                 o_mul_clr,
    output logic                 o_sel_rem,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [4:0]           o_result_index,
    output logic                 o_last,
    output logic                 o_is_remainder,
    output logic                 o_div0
);
    localparam int WI = $clog2(NUM_WORDS);
    localparam int N  = NUM_WORDS * WORD_BITS;
    localparam int BI = $clog2(N);

    typedef enum logic [2:0] {S_IDLE, S_FLAGS, S_DIV, S_MUL, S_MULW, S_EMIT} t_state;
    t_state        r_state;
    logic [3:0]    r_op;
    logic [WI-1:0] r_i, r_j;
    logic [BI-1:0] r_cnt;
    logic [1:0]    r_wait;
    logic          r_rem, r_valid;

    logic w_acc, w_exec;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign w_exec  = w_acc && i_action == mia_pkg::ACT_EXEC && i_opcode <= mia_pkg::OP_CMP;

    assign o_cmd.load     = w_acc && (i_action == mia_pkg::ACT_LOAD_A ||
                                      i_action == mia_pkg::ACT_LOAD_B);
    assign o_cmd.start    = w_exec;
    assign o_cmd.div_step = (r_state == S_DIV);
    assign o_cmd.mul_step = (r_state == S_MUL);
    assign o_mul_clr      = w_exec;
    assign o_widx         = r_i;
    assign o_widx2        = r_j;
    assign o_sel_rem      = r_rem;
    assign o_valid        = r_valid;
    assign o_result_index = 5'(r_i);
    assign o_is_remainder = r_rem;
    assign o_div0 = (r_op == mia_pkg::OP_DIV || r_op == mia_pkg::OP_MOD ||
                     r_op == mia_pkg::OP_DVM) && i_sts.b_zero;
    assign o_last = (r_op == mia_pkg::OP_CMP) ||
                    (r_i == WI'(NUM_WORDS-1) && (r_op != mia_pkg::OP_DVM || r_rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_op    <= mia_pkg::OP_ADD;
            r_i     <= '0;
            r_j     <= '0;
            r_rem   <= 1'b0;
            r_cnt   <= '0;
            r_wait  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_exec) begin
                        r_op    <= i_opcode;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_rem   <= 1'b0;
                        r_state <= S_FLAGS;
                    end
                end
                S_FLAGS: begin
                    if (i_sts.flags_done) begin
                        r_cnt <= BI'(N-1);
                        if (r_op == mia_pkg::OP_MUL) begin
                            r_state <= S_MUL;
                        end else if ((r_op == mia_pkg::OP_DIV || r_op == mia_pkg::OP_MOD ||
                                      r_op == mia_pkg::OP_DVM) && !i_sts.b_zero) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_EMIT;
                            r_valid <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - BI'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_EMIT;
                        r_valid <= 1'b1;
                    end
                end
                S_MUL: begin
                    // all index pairs; pairs past the top word are dropped
                    if (r_j == WI'(NUM_WORDS-1)) begin
                        r_j <= '0;
                        if (r_i == WI'(NUM_WORDS-1)) begin
                            r_i     <= '0;
                            r_state <= S_MULW;
                            r_wait  <= 2'd2;
                        end else begin
                            r_i <= r_i + WI'(1);
                        end
                    end else begin
                        r_j <= r_j + WI'(1);
                    end
                end
                S_MULW: begin
                    r_wait <= r_wait - 2'd1;
                    if (r_wait == 2'd0) begin
                        r_state <= S_EMIT;
                        r_valid <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        if (o_last) begin
                            r_valid <= 1'b0;
                            r_state <= S_IDLE;
                            r_i     <= '0;
                        end else if (r_i == WI'(NUM_WORDS-1)) begin
                            r_i   <= '0;
                            r_rem <= 1'b1;
                        end else begin
                            r_i <= r_i + WI'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/multiword_integer_alu_top.sv
// Sequence: execute runs a flag sweep over all words, then N division steps (div family),
// NUM_WORDS^2 word products (mul) or none, then one result transfer per unstalled cycle.
// Throughput: one item at a time; division is bit-serial, one bit per cycle over N bits,
// multiplication one word product per cycle through a single WORD_BITS multiplier.
// Reset: synchronous active low; operand stores clear to zero, controller returns to idle.
`timescale 1ns / 1ps
module multiword_integer_alu_top #(
    parameter int NUM_WORDS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_word_index,
    input  logic [31:0] i_word_value,
    input  logic [3:0]  i_opcode,
    input  logic [10:0] i_shift_amount,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_word,
    output logic [4:0]  o_result_index,
    output logic        o_is_remainder,
    output logic        o_last,
    output logic [1:0]  o_compare,
    output logic        o_a_is_zero,
    output logic        o_status
);
    localparam int WI = $clog2(NUM_WORDS);

    mia_pkg::t_cmd w_cmd;
    mia_pkg::t_sts w_sts;
    logic [WI-1:0] w_widx, w_widx2;
    logic          w_mul_clr, w_sel_rem, w_div0;
    logic [31:0]   w_word;

    // controller: handshakes and sequencing
    mia_ctrl #(.NUM_WORDS(NUM_WORDS), .WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_opcode(i_opcode),
        .i_sts(w_sts), .o_cmd(w_cmd),
        .o_widx(w_widx), .o_widx2(w_widx2),
        .o_mul_clr(w_mul_clr), .o_sel_rem(w_sel_rem),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_index(o_result_index), .o_last(o_last),
        .o_is_remainder(o_is_remainder), .o_div0(w_div0)
    );

    // datapath: stores, divider, multiplier, word selection
    mia_dp #(.NUM_WORDS(NUM_WORDS), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_action(i_action), .i_word_index(i_word_index),
        .i_word_value(i_word_value), .i_opcode(i_opcode),
        .i_shift_amount(i_shift_amount),
        .i_widx(w_widx), .i_widx2(w_widx2),
        .i_mul_clr(w_mul_clr), .i_sel_rem(w_sel_rem),
        .o_sts(w_sts), .o_word(w_word),
        .o_compare(o_compare), .o_a_is_zero(o_a_is_zero)
    );

    // division by zero forces a zero word; the compare item carries a zero word at index zero
    assign o_result_word = w_div0 ? 32'd0 : w_word;
    assign o_status      = w_div0;
endmodule

### rtl/mia_checker.sv
// Port-level checker for the multiword ALU, bound to the top level.
// Depends on multiword_integer_alu_top_macros.svh.
`timescale 1ns / 1ps
`include "multiword_integer_alu_top_macros.svh"
module mia_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_last,
    input logic       o_status,
    input logic [31:0] o_result_word,
    input logic [4:0] o_result_index
)
;
    `MIA_ASSERT_IMP(a_busy_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `MIA_ASSERT_IMP(a_div0_zero, i_clk, i_rst_n, o_valid && o_status, o_result_word == 32'd0)
    `MIA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_index))
    `MIA_ASSERT_NXT(a_end, i_clk, i_rst_n, o_valid && !i_stall && o_last, !o_valid)
endmodule

bind multiword_integer_alu_top mia_checker u_mia_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_last(o_last), .o_status(o_status),
    .o_result_word(o_result_word), .o_result_index(o_result_index)
);

### test/tb.sv
// Testbench for multiword_integer_alu_top: directed and random load/execute traffic,
// results checked word by word against an in-bench multiword arithmetic predictor.
// Depends on rtl/mia_pkg.sv and the multiword_integer_alu_top RTL.
`timescale 1ns / 1ps
module tb;
    localparam int NW   = 16;
    localparam int WB   = 32;
    localparam int NBIT = NW * WB;

    typedef logic [NBIT-1:0] t_big;

    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  index;
        logic        rem;
        logic        last;
        logic [1:0]  cmp;
        logic        azero;
        logic        status;
    } t_word_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [4:0]  i_word_index;
    logic [31:0] i_word_value;
    logic [3:0]  i_opcode;
    logic [10:0] i_shift_amount;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_word;
    logic [4:0]  o_result_index;
    logic        o_is_remainder;
    logic        o_last;
    logic [1:0]  o_compare;
    logic        o_a_is_zero;
    logic        o_status;

    multiword_integer_alu_top dut (.*);

    // predictor copy of the operand stores
    t_big      opnd_a;
    t_big      opnd_b;
    t_word_out expected_words[$];
    int        mismatches;
    bit        stall_off;   // stretches with the receiver never stalling
    int        stall_run;   // cycles left in a long receiver stall

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Queue every word of one result.
    task automatic push_result(input t_big val, input logic rem, input logic fin,
                               input logic [1:0] c, input logic az, input logic st);
        t_word_out w;
        for (int i = 0; i < NW; i++) begin
            w.word   = val[i*WB +: WB];
            w.index  = 5'(i);
            w.rem    = rem;
            w.last   = fin && (i == NW - 1);
            w.cmp    = c;
            w.azero  = az;
            w.status = st;
            expected_words.push_back(w);
        end
    endtask

    // Predicts the effect of one accepted item.
    task automatic predict_alu(input logic [1:0] act, input logic [4:0] idx,
                               input logic [31:0] val, input logic [3:0] op,
                               input logic [10:0] sh);
        logic [1:0] c;
        logic       az;
        t_big       res;
        t_word_out  w;
        if (act == mia_pkg::ACT_LOAD_A || act == mia_pkg::ACT_LOAD_B) begin
            if (idx < NW) begin
                if (act == mia_pkg::ACT_LOAD_A) opnd_a[idx*WB +: WB] = val;
                else                            opnd_b[idx*WB +: WB] = val;
            end
            return;
        end
        if (act != mia_pkg::ACT_EXEC || op > mia_pkg::OP_CMP) return;
        c  = (opnd_a < opnd_b) ? mia_pkg::CMP_LT :
             (opnd_a == opnd_b) ? mia_pkg::CMP_EQ : mia_pkg::CMP_GT;
        az = (opnd_a == '0);
        case (op)
            mia_pkg::OP_ADD: push_result(opnd_a + opnd_b, 1'b0, 1'b1, c, az, 1'b0);
            mia_pkg::OP_SUB: push_result(opnd_a - opnd_b, 1'b0, 1'b1, c, az, 1'b0);
            mia_pkg::OP_MUL: push_result(opnd_a * opnd_b, 1'b0, 1'b1, c, az, 1'b0);
            mia_pkg::OP_DIV, mia_pkg::OP_MOD, mia_pkg::OP_DVM: begin
                if (opnd_b == '0) begin
                    push_result('0, 1'b0, op != mia_pkg::OP_DVM, c, az, 1'b1);
                    if (op == mia_pkg::OP_DVM) push_result('0, 1'b1, 1'b1, c, az, 1'b1);
                end else if (op == mia_pkg::OP_DIV) begin
                    push_result(opnd_a / opnd_b, 1'b0, 1'b1, c, az, 1'b0);
                end else if (op == mia_pkg::OP_MOD) begin
                    push_result(opnd_a % opnd_b, 1'b0, 1'b1, c, az, 1'b0);
                end else begin
                    push_result(opnd_a / opnd_b, 1'b0, 1'b0, c, az, 1'b0);
                    push_result(opnd_a % opnd_b, 1'b1, 1'b1, c, az, 1'b0);
                end
            end
            mia_pkg::OP_SHL: begin
                res = (sh >= NBIT) ? '0 : opnd_a << sh;
                push_result(res, 1'b0, 1'b1, c, az, 1'b0);
            end
            mia_pkg::OP_SHR: begin
                res = (sh >= NBIT) ? '0 : opnd_a >> sh;
                push_result(res, 1'b0, 1'b1, c, az, 1'b0);
            end
            mia_pkg::OP_OR: push_result(opnd_a | opnd_b, 1'b0, 1'b1, c, az, 1'b0);
            default: begin
                w = '{word: '0, index: '0, rem: 1'b0, last: 1'b1, cmp: c,
                      azero: az, status: 1'b0};
                expected_words.push_back(w);
            end
        endcase
    endtask

    // Sender gap: mostly none or short, now and then long.
    function automatic int gap_len();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        return n;
    endfunction

    // Sends one item and waits for its transfer.
    task automatic send_item(input logic [1:0] act, input logic [4:0] idx,
                             input logic [31:0] val, input logic [3:0] op,
                             input logic [10:0] sh);
        int n;
        i_valid        <= 1'b1;
        i_action       <= act;
        i_word_index   <= idx;
        i_word_value   <= val;
        i_opcode       <= op;
        i_shift_amount <= sh;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_alu(act, idx, val, op, sh);
        n = gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic load_both(input t_big a, input t_big b);
        for (int i = 0; i < NW; i++)
            send_item(mia_pkg::ACT_LOAD_A, 5'(i), a[i*WB +: WB], mia_pkg::OP_ADD, '0);
        for (int i = 0; i < NW; i++)
            send_item(mia_pkg::ACT_LOAD_B, 5'(i), b[i*WB +: WB], mia_pkg::OP_ADD, '0);
    endtask

    function automatic t_big rand_big(input int words);
        t_big v;
        v = '0;
        for (int i = 0; i < words; i++) v[i*WB +: WB] = $urandom();
        return v;
    endfunction

    function automatic logic [3:0] rand_op();
        return 4'($urandom_range(mia_pkg::OP_ADD, mia_pkg::OP_CMP));
    endfunction

    // Extremes: compare and divmod on zero operands, all ops on all ones, zero divisor, large shifts.
    task automatic test_directed();
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_CMP, '0);
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_DVM, '0);
        load_both('1, '1);
        for (int op = mia_pkg::OP_ADD; op <= mia_pkg::OP_CMP; op++)
            send_item(mia_pkg::ACT_EXEC, '0, '0, 4'(op), '0);
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_SHL, 11'(NBIT - 1));
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_SHR, 11'(NBIT));
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_SHL, 11'd1024);
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_SHR, 11'h7FF);
        // an out-of-range load, unused action and unused opcode do nothing
        send_item(mia_pkg::ACT_LOAD_B, 5'd31, 32'h0, mia_pkg::OP_ADD, '0);
        send_item(2'd3, 5'd0, 32'h0, mia_pkg::OP_ADD, '0);
        send_item(mia_pkg::ACT_EXEC, '0, '0, 4'd15, '0);
        load_both(rand_big(NW), '0);
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_DIV, '0);
        send_item(mia_pkg::ACT_EXEC, '0, '0, mia_pkg::OP_MOD, '0);
    endtask

    // Random operands of varying length, then a few random executions.
    task automatic test_random();
        t_big a, b;
        for (int n = 0; n < 2; n++) begin
            a = rand_big($urandom_range(0, NW));
            b = ($urandom_range(0, 4) == 0) ? a : rand_big($urandom_range(0, NW));
            if ($urandom_range(0, 5) == 0) b = '0;
            stall_off = ($urandom_range(0, 3) == 0);
            load_both(a, b);
            for (int k = 0; k < 4; k++)
                send_item(mia_pkg::ACT_EXEC, '0, '0, rand_op(),
                          11'($urandom_range(0, 1100)));
        end
        stall_off = 1'b0;
    endtask

    // Single-word updates with noise: bad indexes, unused action and opcodes.
    task automatic test_noise();
        for (int n = 0; n < 10; n++) begin
            send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), $urandom(),
                      4'($urandom_range(0, 15)), 11'($urandom()));
        end
    endtask

    // Receiver: random stalls, checks each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_word_out got, exp_w;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_run = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{word: o_result_word, index: o_result_index, rem: o_is_remainder,
                        last: o_last, cmp: o_compare, azero: o_a_is_zero,
                        status: o_status};
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", exp_w, got);
                    end
                end
            end
            if (stall_off) begin
                i_stall <= 1'b0;
            end else if (stall_run > 0) begin
                stall_run = stall_run - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                stall_run = $urandom_range(10, 40);
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_action = '0; i_word_index = '0; i_word_value = '0;
        i_opcode = '0; i_shift_amount = '0;
        opnd_a = '0; opnd_b = '0; mismatches = 0; stall_off = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_noise();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (NW * NW + NBIT + 50) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS multiword_integer_alu_top");
        else
            $display("FAIL multiword_integer_alu_top");
        $finish;
    end

    // Overall limit, far above the slowest correct run.
    initial begin
        #50_000_000;
        $display("FAIL multiword_integer_alu_top");
        $finish;
    end
endmodule
